// ===== hdl/multiplexed_display_crossfade_unit_assert.svh =====
// Assertion helpers shared by the display crossfade RTL.
`ifndef MULTIPLEXED_DISPLAY_CROSSFADE_UNIT_ASSERT_SVH
`define MULTIPLEXED_DISPLAY_CROSSFADE_UNIT_ASSERT_SVH

// Checked on every rising edge, masked while reset is asserted.
`define MDCF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define MDCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mdcf_pkg.sv =====
`default_nettype none

package mdcf_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int LOAD_INPUTS = 4;
    localparam int LOAD_N      = (DIGIT_COUNT < LOAD_INPUTS) ? DIGIT_COUNT : LOAD_INPUTS;
    localparam int SLOT_W      = $clog2(DIGIT_COUNT);

    localparam int CMD_W     = 2;
    localparam int DIGIT_W   = 4;
    localparam int ANODE_W   = 3;
    localparam int TIME_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [ANODE_W-1:0] BLANK_ANODE  = ANODE_W'(4);
    localparam logic [DIGIT_W-1:0] ALL_CATHODES = DIGIT_W'(10);

    localparam logic [TIME_W-1:0] FULL_DUTY_RST  = TIME_W'(20800);
    localparam logic [TIME_W-1:0] FADE_STEP_RST  = TIME_W'(800);
    localparam logic [TIME_W-1:0] FADE_FLOOR_RST = TIME_W'(1000);

    typedef enum logic [CMD_W-1:0] {
        CMD_SLOT   = 2'd0,
        CMD_SWITCH = 2'd1,
        CMD_BLANK  = 2'd2,
        CMD_LOAD   = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FULL_DUTY  = 2'd0,
        REG_FADE_STEP  = 2'd1,
        REG_FADE_FLOOR = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [TIME_W-1:0] full_duty;
        logic [TIME_W-1:0] fade_step;
        logic [TIME_W-1:0] fade_floor;
    } t_cfg;

    typedef struct packed {
        t_cmd                                  cmd;
        logic [LOAD_INPUTS-1:0][DIGIT_W-1:0]   new_digit;
    } t_item;

    typedef struct packed {
        logic [ANODE_W-1:0] anode;
        logic [DIGIT_W-1:0] numeral;
        logic [TIME_W-1:0]  switch_time;
        logic               fading;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/multiplexed_display_crossfade_unit.sv =====
// Multiplexed four-digit display driver with old/new numeral cross-fade.
//
// Input channel: i_in_valid / o_in_stall carry one event per beat (i_cmd plus
// the four new numerals, which only a load uses). Output channel:
// o_out_valid / i_out_stall carry anode, numeral, switch compare time and the
// fading flag. Slot start and blank always give a beat; switch point gives one
// only while fading on a changing digit; load gives none.
// Config: i_cfg_valid / o_cfg_ready write full_duty, fade_step or fade_floor
// by index; write only while no event is in flight.
// An accepted event is held in the input stage; its result is then registered
// in the output register and offered from then on. Throughput is one event per
// cycle unless the receiver stalls, set by the single input stage feeding one output register.
// Reset (synchronous, active low) empties both stages, clears slot, numerals
// and fade state, and loads the register reset values.
// When the receiver stalls with a result waiting, the input stage holds its
// event and o_in_stall rises once that stage is full.
`default_nettype none

`include "multiplexed_display_crossfade_unit_assert.svh"

module multiplexed_display_crossfade_unit
    import mdcf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [DIGIT_W-1:0]    i_new_digit0,
    input  wire logic [DIGIT_W-1:0]    i_new_digit1,
    input  wire logic [DIGIT_W-1:0]    i_new_digit2,
    input  wire logic [DIGIT_W-1:0]    i_new_digit3,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [ANODE_W-1:0]         o_anode,
    output logic [DIGIT_W-1:0]         o_numeral,
    output logic [TIME_W-1:0]          o_switch_time,
    output logic                       o_fading,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [TIME_W-1:0]     i_cfg_data
);

    t_cfg     r_cfg;
    logic     r_in_valid;
    t_item    r_in;
    logic     r_out_valid;
    t_result  r_out;

    logic     w_accept;
    logic     w_go;
    logic     w_res_valid;
    t_result  w_res;

    assign o_cfg_ready = 1'b1;

    assign w_go       = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_duty  <= FULL_DUTY_RST;
            r_cfg.fade_step  <= FADE_STEP_RST;
            r_cfg.fade_floor <= FADE_FLOOR_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_FULL_DUTY:  r_cfg.full_duty  <= i_cfg_data;
                REG_FADE_STEP:  r_cfg.fade_step  <= i_cfg_data;
                REG_FADE_FLOOR: r_cfg.fade_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in.cmd          <= t_cmd'(i_cmd);
            r_in.new_digit[0] <= i_new_digit0;
            r_in.new_digit[1] <= i_new_digit1;
            r_in.new_digit[2] <= i_new_digit2;
            r_in.new_digit[3] <= i_new_digit3;
        end
    end

    mdcf_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_item      (r_in),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go) begin
            r_out_valid <= w_res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_anode       = r_out.anode;
    assign o_numeral     = r_out.numeral;
    assign o_switch_time = r_out.switch_time;
    assign o_fading      = r_out.fading;

    `MDCF_ASSERT(a_result_lands, i_clk, i_rst_n, (w_go && w_res_valid) |=> r_out_valid, "result beat lost")
    `MDCF_ASSERT(a_held_while_blocked, i_clk, i_rst_n, (r_in_valid && !w_go) |=> r_in_valid, "blocked event dropped")
    `MDCF_ASSERT(a_out_held, i_clk, i_rst_n, (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out)), "stalled beat changed")

endmodule

`default_nettype wire

// ===== hdl/mdcf_core.sv =====
`default_nettype none

`include "multiplexed_display_crossfade_unit_assert.svh"

module mdcf_core
    import mdcf_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_go,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output logic         o_res_valid,
    output t_result      o_res
);

    logic [SLOT_W-1:0]                     r_slot, n_slot;
    logic [DIGIT_COUNT-1:0][DIGIT_W-1:0]   r_shown, n_shown;
    logic [DIGIT_COUNT-1:0][DIGIT_W-1:0]   r_pending, n_pending;
    logic [TIME_W-1:0]                     r_fade_time, n_fade_time;
    logic                                  r_fade_active, n_fade_active;

    logic               w_wrap;
    logic [SLOT_W-1:0]  w_next_slot;
    logic [TIME_W-1:0]  w_sub;
    logic               w_done;

    assign w_wrap      = (r_slot == SLOT_W'(DIGIT_COUNT - 1));
    assign w_next_slot = w_wrap ? '0 : r_slot + 1'b1;
    assign w_sub       = r_fade_time - i_cfg.fade_step;
    // underflow ends the fade just like dropping below the floor
    assign w_done      = (r_fade_time < i_cfg.fade_step) || (w_sub < i_cfg.fade_floor);

    always_comb begin
        n_slot        = r_slot;
        n_shown       = r_shown;
        n_pending     = r_pending;
        n_fade_time   = r_fade_time;
        n_fade_active = r_fade_active;
        o_res_valid   = 1'b0;
        o_res         = '0;
        unique case (i_item.cmd)
            CMD_SLOT: begin
                n_slot = w_next_slot;
                if (w_wrap && r_fade_active) begin
                    if (w_done) begin
                        n_fade_time   = i_cfg.full_duty;
                        n_fade_active = 1'b0;
                        n_shown       = r_pending;
                    end else begin
                        n_fade_time = w_sub;
                    end
                end
                o_res_valid   = 1'b1;
                o_res.anode   = ANODE_W'(n_slot);
                o_res.numeral = n_shown[n_slot];
                o_res.switch_time = (n_fade_active && (n_pending[n_slot] != n_shown[n_slot]))
                                    ? n_fade_time : i_cfg.full_duty;
                o_res.fading  = n_fade_active;
            end
            CMD_SWITCH: begin
                if (r_fade_active && (r_pending[r_slot] != r_shown[r_slot])) begin
                    o_res_valid   = 1'b1;
                    o_res.anode   = ANODE_W'(r_slot);
                    o_res.numeral = r_pending[r_slot];
                    o_res.fading  = r_fade_active;
                end
            end
            CMD_BLANK: begin
                o_res_valid   = 1'b1;
                o_res.anode   = BLANK_ANODE;
                o_res.numeral = ALL_CATHODES;
                o_res.fading  = r_fade_active;
            end
            CMD_LOAD: begin
                n_pending = '0;
                for (int i = 0; i < LOAD_N; i++) begin
                    n_pending[i] = i_item.new_digit[i];
                end
                n_fade_time   = i_cfg.full_duty;
                n_fade_active = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot        <= '0;
            r_shown       <= '0;
            r_pending     <= '0;
            r_fade_time   <= FULL_DUTY_RST;
            r_fade_active <= 1'b0;
        end else if (i_go) begin
            r_slot        <= n_slot;
            r_shown       <= n_shown;
            r_pending     <= n_pending;
            r_fade_time   <= n_fade_time;
            r_fade_active <= n_fade_active;
        end
    end

    `MDCF_ASSERT(a_slot_range, i_clk, i_rst_n, r_slot <= SLOT_W'(DIGIT_COUNT - 1), "slot index past last digit")
    `MDCF_ASSERT(a_load_starts_fade, i_clk, i_rst_n, (i_go && (i_item.cmd == CMD_LOAD)) |=> r_fade_active, "load did not start a fade")
    `MDCF_ASSERT_ALWAYS(a_fade_end_commits, i_clk, $fell(r_fade_active) |-> (r_shown == r_pending), "fade ended without committing numerals")

endmodule

`default_nettype wire

// ===== verif/crossfade_checker.sv =====
`timescale 1ns / 1ps

module crossfade_checker
    import mdcf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire logic [CMD_W-1:0]      i_cmd,
    input  wire logic [DIGIT_W-1:0]    i_new_digit0,
    input  wire logic [DIGIT_W-1:0]    i_new_digit1,
    input  wire logic [DIGIT_W-1:0]    i_new_digit2,
    input  wire logic [DIGIT_W-1:0]    i_new_digit3,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire logic [ANODE_W-1:0]    i_anode,
    input  wire logic [DIGIT_W-1:0]    i_numeral,
    input  wire logic [TIME_W-1:0]     i_switch_time,
    input  wire logic                  i_fading,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [TIME_W-1:0]     i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    typedef logic [LOAD_INPUTS-1:0][DIGIT_W-1:0] numerals_t;

    logic [TIME_W-1:0]  full_duty;
    logic [TIME_W-1:0]  fade_step;
    logic [TIME_W-1:0]  fade_floor;
    logic [SLOT_W-1:0]  lit_slot;
    logic [DIGIT_W-1:0] shown [DIGIT_COUNT];
    logic [DIGIT_W-1:0] incoming [DIGIT_COUNT];
    logic [TIME_W-1:0]  fade_time;
    logic               fade_on;
    t_result            display_beats [$];
    int                 fail_count = 0;

    function automatic bit digit_changes(int s);
        return fade_on && (incoming[s] != shown[s]);
    endfunction

    // Advance the display state by one event and queue any beat it yields.
    task automatic apply_display_event(input t_cmd cmd, input numerals_t nd);
        int      nxt;
        bit      ends;
        t_result r;
        case (cmd)
            CMD_SLOT: begin
                nxt = int'(lit_slot) + 1;
                if (nxt >= DIGIT_COUNT) begin
                    nxt = 0;
                    if (fade_on) begin
                        // a step larger than the time left counts as below the floor
                        if (fade_time < fade_step) begin
                            ends = 1'b1;
                        end else begin
                            fade_time = fade_time - fade_step;
                            ends = (fade_time < fade_floor);
                        end
                        if (ends) begin
                            fade_time = full_duty;
                            fade_on = 1'b0;
                            for (int i = 0; i < DIGIT_COUNT; i++) shown[i] = incoming[i];
                        end
                    end
                end
                lit_slot = SLOT_W'(nxt);
                r.anode = ANODE_W'(nxt);
                r.numeral = shown[nxt];
                r.switch_time = digit_changes(nxt) ? fade_time : full_duty;
                r.fading = fade_on;
                display_beats.push_back(r);
            end
            CMD_SWITCH: begin
                if (digit_changes(int'(lit_slot))) begin
                    r.anode = ANODE_W'(lit_slot);
                    r.numeral = incoming[lit_slot];
                    r.switch_time = '0;
                    r.fading = fade_on;
                    display_beats.push_back(r);
                end
            end
            CMD_BLANK: begin
                r.anode = BLANK_ANODE;
                r.numeral = ALL_CATHODES;
                r.switch_time = '0;
                r.fading = fade_on;
                display_beats.push_back(r);
            end
            default: begin
                for (int i = 0; i < DIGIT_COUNT; i++) incoming[i] = '0;
                for (int i = 0; i < LOAD_N; i++) incoming[i] = nd[i];
                fade_time = full_duty;
                fade_on = 1'b1;
            end
        endcase
    endtask

    function automatic void compare_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    task automatic check_beat(input t_result got);
        t_result want;
        if (display_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual anode=%0d numeral=%0d ",
                     $time, got.anode, got.numeral,
                     "switch_time=%0d fading=%0d", got.switch_time, got.fading);
            fail_count++;
        end else begin
            want = display_beats.pop_front();
            compare_field("anode", want.anode, got.anode);
            compare_field("numeral", want.numeral, got.numeral);
            compare_field("switch_time", want.switch_time, got.switch_time);
            compare_field("fading", want.fading, got.fading);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            full_duty = FULL_DUTY_RST;
            fade_step = FADE_STEP_RST;
            fade_floor = FADE_FLOOR_RST;
            lit_slot = '0;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                shown[i] = '0;
                incoming[i] = '0;
            end
            fade_time = FULL_DUTY_RST;
            fade_on = 1'b0;
            display_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_FULL_DUTY:  full_duty = i_cfg_data;
                    REG_FADE_STEP:  fade_step = i_cfg_data;
                    REG_FADE_FLOOR: fade_floor = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                apply_display_event(t_cmd'(i_cmd),
                                    {i_new_digit3, i_new_digit2, i_new_digit1, i_new_digit0});
            end
            if (i_out_valid && !i_out_stall) begin
                check_beat('{anode: i_anode, numeral: i_numeral,
                             switch_time: i_switch_time, fading: i_fading});
            end
        end
        o_fail_count <= fail_count;
        o_pending <= display_beats.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import mdcf_pkg::*;

    typedef logic [LOAD_INPUTS-1:0][DIGIT_W-1:0] numerals_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 ev_valid = 1'b0;
    logic                 ev_stall;
    t_cmd                 ev_cmd = CMD_SLOT;
    numerals_t            ev_digits = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic [ANODE_W-1:0]   res_anode;
    logic [DIGIT_W-1:0]   res_numeral;
    logic [TIME_W-1:0]    res_switch_time;
    logic                 res_fading;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data = '0;

    int        fail_count;
    int        beats_due;
    int        sent = 0;
    int        hold_left = 0;
    logic      hold_req = 1'b0;
    logic      gaps_on = 1'b1;
    numerals_t last_load = '0;

    always #5 clk = ~clk;

    multiplexed_display_crossfade_unit dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (ev_valid),
        .o_in_stall    (ev_stall),
        .i_cmd         (ev_cmd),
        .i_new_digit0  (ev_digits[0]),
        .i_new_digit1  (ev_digits[1]),
        .i_new_digit2  (ev_digits[2]),
        .i_new_digit3  (ev_digits[3]),
        .o_out_valid   (res_valid),
        .i_out_stall   (res_stall),
        .o_anode       (res_anode),
        .o_numeral     (res_numeral),
        .o_switch_time (res_switch_time),
        .o_fading      (res_fading),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    crossfade_checker checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (ev_valid),
        .i_in_stall    (ev_stall),
        .i_cmd         (ev_cmd),
        .i_new_digit0  (ev_digits[0]),
        .i_new_digit1  (ev_digits[1]),
        .i_new_digit2  (ev_digits[2]),
        .i_new_digit3  (ev_digits[3]),
        .i_out_valid   (res_valid),
        .i_out_stall   (res_stall),
        .i_anode       (res_anode),
        .i_numeral     (res_numeral),
        .i_switch_time (res_switch_time),
        .i_fading      (res_fading),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (beats_due)
    );

    // Receiver: random stalls, plus one long hold-off when requested.
    always @(posedge clk) begin
        if (hold_req) begin
            hold_left <= 150;
            res_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end else begin
            res_stall <= gaps_on && ($urandom_range(99) < 9);
        end
    end

    initial begin
        #1ms;
        $display("Test completed with failures");
        $finish;
    end

    // Leaves valid high on return so back-to-back beats need no re-raise.
    task automatic send_event(input t_cmd c, input numerals_t nd);
        while (gaps_on && $urandom_range(99) < 9) begin
            ev_valid <= 1'b0;
            @(posedge clk);
        end
        ev_valid <= 1'b1;
        ev_cmd <= c;
        ev_digits <= nd;
        do @(posedge clk); while (ev_stall);
        sent++;
    endtask

    task automatic settle();
        ev_valid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0) @(posedge clk);
        // a load or a silent switch may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [TIME_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic program_regs(input logic [TIME_W-1:0] duty, input logic [TIME_W-1:0] step,
                                input logic [TIME_W-1:0] floor_val);
        write_reg(REG_FULL_DUTY, duty);
        write_reg(REG_FADE_STEP, step);
        write_reg(REG_FADE_FLOOR, floor_val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic numerals_t fresh_numerals();
        numerals_t v;
        int        r;
        for (int i = 0; i < LOAD_INPUTS; i++) begin
            r = $urandom_range(99);
            if (r < 70) v[i] = DIGIT_W'($urandom_range(9));
            else if (r < 85) v[i] = last_load[i];
            else v[i] = DIGIT_W'($urandom);
        end
        last_load = v;
        return v;
    endfunction

    task automatic load_numerals(input numerals_t nd);
        last_load = nd;
        send_event(CMD_LOAD, nd);
    endtask

    // Mostly slot/switch scan pairs; the rest is broken sequences, blanks and loads.
    task automatic run_random(input int n);
        int stop;
        int r;
        stop = sent + n;
        while (sent < stop) begin
            r = $urandom_range(99);
            if (r < 70) begin
                send_event(CMD_SLOT, numerals_t'($urandom));
                send_event(CMD_SWITCH, numerals_t'($urandom));
            end else if (r < 82) begin
                send_event(CMD_SLOT, numerals_t'($urandom));
            end else if (r < 92) begin
                send_event(CMD_SWITCH, numerals_t'($urandom));
            end else if (r < 97) begin
                send_event(CMD_BLANK, numerals_t'($urandom));
            end else begin
                send_event(CMD_LOAD, fresh_numerals());
            end
        end
    endtask

    initial begin
        logic [TIME_W-1:0] duty;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: idle display, then a fade with above-nine and unchanged digits
        send_event(CMD_BLANK, '0);
        send_event(CMD_SWITCH, '1);
        repeat (4) send_event(CMD_SLOT, '0);
        load_numerals({4'd10, 4'd15, 4'd0, 4'd9});
        repeat (4) begin
            send_event(CMD_SLOT, '0);
            send_event(CMD_SWITCH, '0);
        end
        send_event(CMD_BLANK, '0);
        load_numerals('0);
        send_event(CMD_SLOT, '0);
        send_event(CMD_SWITCH, '0);
        load_numerals({4'd9, 4'd9, 4'd9, 4'd9});
        send_event(CMD_SWITCH, '1);

        for (int ph = 0; ph < 8; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1: program_regs('1, '1, '0);        // underflow on the second scan
                    2: program_regs('0, 16'd1, '1);     // ends on the first scan
                    3: program_regs(16'd500, '0, 16'd1000);
                    4: program_regs(16'd3000, '0, '0);  // never ends by itself
                    5: program_regs(TIME_W'($urandom), TIME_W'($urandom), TIME_W'($urandom));
                    default: begin
                        duty = TIME_W'($urandom_range(65535, 1000));
                        program_regs(duty, duty / TIME_W'($urandom_range(8, 2)),
                                     TIME_W'($urandom_range(duty / 2)));
                    end
                endcase
            end
            gaps_on <= (ph != 4);
            if (ph == 2) begin
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            load_numerals(fresh_numerals());
            run_random(88);
        end
        settle();

        if (fail_count == 0 && beats_due == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== multiplexed_display_crossfade_unit.f =====
+incdir+hdl
hdl/mdcf_pkg.sv
hdl/mdcf_core.sv
hdl/multiplexed_display_crossfade_unit.sv
verif/crossfade_checker.sv
verif/tb.sv
